// ===== rtl/dkts_pkg.sv =====
`default_nettype none

package dkts_pkg;

    localparam int MAX_ITEMS = 8;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W     = 16;
    localparam int TAG_W     = 8;
    localparam int DATA_W    = KEY_W + TAG_W;

    // key in the low bits, tag above it
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_LD_I,
        ST_CMP,
        ST_WR_I,
        ST_OUT_RD,
        ST_OUT_LD
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/dkts_store.sv =====
`default_nettype none

module dkts_store (
    input  wire              i_clk,
    input  wire dkts_pkg::t_mem_req i_req,
    output dkts_pkg::t_entry  o_rd_data
);
    import dkts_pkg::*;

    t_entry r_mem [MAX_ITEMS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/descending_key_tag_sorter.sv =====
// Loading: one item per cycle, a batch of up to eight items into the store.
// Sort after the last item: one store pass per position but the last, with one
// compare per cycle over the store port. Results then leave one per cycle from
// the output register while i_m_tready holds, the first read in ST_OUT_RD and
// registered in ST_OUT_LD. The next batch loads while the final result waits.
// Reset (i_rst_n low, synchronous) empties the batch and the output register.
`default_nettype none

module descending_key_tag_sorter (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    input  wire [dkts_pkg::DATA_W-1:0] i_s_tdata,   // sort_key[15:0], item_tag[23:16]
    input  wire                        i_s_tlast,   // last_item
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    output logic [dkts_pkg::DATA_W-1:0] o_m_tdata,  // sorted_key[15:0], sorted_tag[23:16]
    output logic                       o_m_tlast,   // final_result
    output logic                       o_m_tuser    // batch_overflow
);
    import dkts_pkg::*;

    t_state           r_state,     n_state;
    logic [CNT_W-1:0] r_count,     n_count;
    logic             r_ovf,       n_ovf;
    logic [IDX_W-1:0] r_i,         n_i;
    logic [IDX_W-1:0] r_j,         n_j;
    logic [IDX_W-1:0] r_k,         n_k;
    t_entry           r_cur,       n_cur;
    logic             r_out_valid, n_out_valid;
    t_entry           r_out,       n_out;
    logic             r_out_last,  n_out_last;
    logic             r_out_ovf,   n_out_ovf;

    t_mem_req         mem_req;
    t_entry           rd_data;
    logic             out_free;
    logic             k_last;

    dkts_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_cur      <= n_cur;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign k_last   = (CNT_W'(r_k) + CNT_W'(1)) == r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        mem_req     = '0;

        case (r_state)
            ST_LOAD: begin
                if (i_s_tvalid) begin
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = r_count[IDX_W-1:0];
                        mem_req.wr_data = t_entry'(i_s_tdata);
                        n_count         = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_i = '0;
                        n_k = '0;
                        if (n_count >= CNT_W'(2)) begin
                            n_state = ST_RD_I;
                        end else begin
                            n_state = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_RD_I: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_i;
                n_state         = ST_LD_I;
            end
            ST_LD_I: begin
                n_cur           = rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_i + IDX_W'(1);
                n_j             = r_i + IDX_W'(1);
                n_state         = ST_CMP;
            end
            ST_CMP: begin
                // position i lives in r_cur; swap writes the old one back to j
                if (r_cur.key < rd_data.key) begin
                    n_cur           = rd_data;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_j;
                    mem_req.wr_data = r_cur;
                end
                if ((CNT_W'(r_j) + CNT_W'(1)) < r_count) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_j + IDX_W'(1);
                    n_j             = r_j + IDX_W'(1);
                end else begin
                    n_state = ST_WR_I;
                end
            end
            ST_WR_I: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_i;
                mem_req.wr_data = r_cur;
                if ((CNT_W'(r_i) + CNT_W'(3)) <= r_count) begin
                    n_i             = r_i + IDX_W'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_i + IDX_W'(1);
                    n_state         = ST_LD_I;
                end else begin
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_k;
                n_state         = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = rd_data;
                    n_out_last  = k_last;
                    n_out_ovf   = r_ovf;
                    if (k_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k             = r_k + IDX_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_LOAD);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_ovf;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("batch count beyond capacity");

    a_no_rw_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("store read and write hit the same entry");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> ((r_j > r_i) && (CNT_W'(r_j) < r_count)))
        else $error("compare index out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT_LD && !out_free) |=> (r_state == ST_OUT_LD && $stable(r_k)))
        else $error("result position moved while output stalled");
`endif

endmodule

`default_nettype wire
